@@ rtl/core/websocket_message_reassembler_core_assert.svh @@
// Assertion macros shared by the checker of the message reassembler.
// Needs nothing else; the including file supplies clock, reset and signals.
`ifndef WEBSOCKET_MESSAGE_REASSEMBLER_CORE_ASSERT_SVH
`define WEBSOCKET_MESSAGE_REASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSMR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSMR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wsmr_pkg.sv @@
// Shared types, codes and helper functions of the WebSocket message reassembler.
// No dependencies; every other file but the assertion macro header imports it.
package wsmr_pkg;

  localparam int unsigned LEN_W = 63;
  localparam int unsigned CONTROL_MAX_LEN_DEF = 125;

  localparam logic [15:0] CODE_NORMAL   = 16'd1000;
  localparam logic [15:0] CODE_PROTOCOL = 16'd1002;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BYTE   = 1'b1;

  localparam logic [3:0] OPC_CONT   = 4'd0;
  localparam logic [3:0] OPC_TEXT   = 4'd1;
  localparam logic [3:0] OPC_BINARY = 4'd2;
  localparam logic [3:0] OPC_CLOSE  = 4'd8;
  localparam logic [3:0] OPC_PING   = 4'd9;
  localparam logic [3:0] OPC_PONG   = 4'd10;

  typedef enum logic [2:0] {
    ROUTE_SINGLE = 3'd0,
    ROUTE_FRAG   = 3'd1,
    ROUTE_PING   = 3'd2,
    ROUTE_PONG   = 3'd3,
    ROUTE_CLOSE  = 3'd4,
    ROUTE_DROP   = 3'd5
  } route_t;

  typedef enum logic [3:0] {
    EV_FRAG_STORED = 4'd0,
    EV_TEXT        = 4'd1,
    EV_BINARY      = 4'd2,
    EV_PING        = 4'd3,
    EV_PONG        = 4'd4,
    EV_CLOSE       = 4'd5,
    EV_BAD_UTF8    = 4'd6,
    EV_ORPHAN      = 4'd7,
    EV_FRAG_CTRL   = 4'd8,
    EV_LONG_CTRL   = 4'd9,
    EV_UNKNOWN     = 4'd10
  } event_t;

  // Close payload position: high code byte, low code byte, then reason text.
  localparam logic [1:0] CLOSE_IDX_HI     = 2'd0;
  localparam logic [1:0] CLOSE_IDX_LO     = 2'd1;
  localparam logic [1:0] CLOSE_IDX_REASON = 2'd2;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  out_byte;
    logic [2:0]  byte_kind;
    logic        starts_message;
    logic        frame_end;
    logic [3:0]  event_res;
    logic [15:0] close_code;
  } result_t;

  typedef struct packed {
    logic [1:0] left;
    logic       bad;
  } utf8_t;

  // Lenient UTF-8 tracker: lead and continuation patterns only.
  function automatic utf8_t utf8_feed(input logic [7:0] b, input utf8_t cur);
    utf8_t nxt;
    nxt = cur;
    if (cur.left != 2'd0) begin
      if ((b & 8'hC0) != 8'h80) begin
        nxt.bad = 1'b1;
      end else begin
        nxt.left = cur.left - 2'd1;
      end
    end else if ((b & 8'h80) == 8'h00) begin
      nxt.left = 2'd0;
    end else if ((b & 8'hE0) == 8'hC0) begin
      nxt.left = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      nxt.left = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      nxt.left = 2'd3;
    end else begin
      nxt.bad = 1'b1;
    end
    return nxt;
  endfunction

endpackage

@@ rtl/core/websocket_message_reassembler_core.sv @@
// WebSocket receive-side message reassembler. Each request is either a decoded
// frame header (op 0) or one unmasked payload byte (op 1). Every payload byte
// of a live frame comes back at once as a result, tagged in byte_kind by its
// destination (single-frame data, fragmented data, ping, pong, close or
// discarded). The last byte of a frame, or the header of an empty frame,
// also carries frame_end and the verdict in event_res; for a close frame
// close_code holds the status code (1000 when the payload is shorter than two
// bytes, 1002 when the reason is not valid UTF-8). Headers of nonempty frames
// and bytes arriving outside any frame give no result. Since bytes leave
// before the verdict, the consumer must discard bytes of a dropped message,
// and on starts_message it discards any fragments it still holds. The block
// takes one request per clock cycle while the skid entry is free; each result
// is formed in the cycle of its request and registered in the output register,
// or in the skid entry when that is full. The longest path is the 63-bit frame
// byte countdown with its zero test. An output register plus one skid entry
// decouple the two sides, so input stalls only when both hold a result not yet taken.
module websocket_message_reassembler_core #(
  parameter int unsigned CONTROL_MAX_LEN = wsmr_pkg::CONTROL_MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [3:0]                 opcode,
  input  logic                       fin,
  input  logic [wsmr_pkg::LEN_W-1:0] frame_len,
  input  logic [7:0]                 in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       has_byte,
  output logic [7:0]                 out_byte,
  output logic [2:0]                 byte_kind,
  output logic                       starts_message,
  output logic                       frame_end,
  output logic [3:0]                 event_res,
  output logic [15:0]                close_code
);
  import wsmr_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t head;
  logic    room;

  // A request is taken whenever the skid entry is free, whether or not it
  // will produce a result.
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  wsmr_engine #(
    .CONTROL_MAX_LEN(CONTROL_MAX_LEN)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (op),
    .opcode      (opcode),
    .fin         (fin),
    .frame_len   (frame_len),
    .in_byte     (in_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsmr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign has_byte       = head.has_byte;
  assign out_byte       = head.out_byte;
  assign byte_kind      = head.byte_kind;
  assign starts_message = head.starts_message;
  assign frame_end      = head.frame_end;
  assign event_res      = head.event_res;
  assign close_code     = head.close_code;

endmodule

@@ rtl/core/wsmr_engine.sv @@
// Frame tracking state and per-item result logic of the message reassembler.
// Depends on wsmr_pkg; feeds at most one result a cycle, on accepted requests.
module wsmr_engine #(
  parameter int unsigned CONTROL_MAX_LEN = wsmr_pkg::CONTROL_MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     op,
  input  logic [3:0]               opcode,
  input  logic                     fin,
  input  logic [wsmr_pkg::LEN_W-1:0] frame_len,
  input  logic [7:0]               in_byte,
  output logic                     res_valid,
  output wsmr_pkg::result_t        res
);
  import wsmr_pkg::*;

  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [3:0]       frame_opcode, frame_opcode_next;
  logic             frame_fin, frame_fin_next;
  route_t           frame_route, frame_route_next;
  logic             first_pending, first_pending_next;
  logic             frag_is_text, frag_is_text_next;
  logic             frag_nonempty, frag_nonempty_next;
  utf8_t            frag_utf8, frag_utf8_next;
  utf8_t            msg_utf8, msg_utf8_next;
  logic [1:0]       close_index, close_index_next;
  logic [15:0]      close_value, close_value_next;
  event_t           drop_event, drop_event_next;

  always_comb begin
    logic             emit;
    logic             is_end;
    logic             with_byte;
    event_t           ev;
    logic [15:0]      code;

    bytes_left_next    = bytes_left;
    frame_opcode_next  = frame_opcode;
    frame_fin_next     = frame_fin;
    frame_route_next   = frame_route;
    first_pending_next = first_pending;
    frag_is_text_next  = frag_is_text;
    frag_nonempty_next = frag_nonempty;
    frag_utf8_next     = frag_utf8;
    msg_utf8_next      = msg_utf8;
    close_index_next   = close_index;
    close_value_next   = close_value;
    drop_event_next    = drop_event;
    emit      = 1'b0;
    is_end    = 1'b0;
    with_byte = 1'b0;
    ev        = EV_FRAG_STORED;
    code      = 16'd0;

    if (accept) begin
      if (op == OP_HEADER) begin
        frame_opcode_next  = opcode;
        frame_fin_next     = fin;
        bytes_left_next    = frame_len;
        first_pending_next = 1'b0;
        drop_event_next    = EV_FRAG_STORED;
        if (opcode == OPC_CONT) begin
          if (!frag_nonempty) begin
            frame_route_next = ROUTE_DROP;
            drop_event_next  = EV_ORPHAN;
          end else begin
            frame_route_next = ROUTE_FRAG;
          end
        end else if (opcode == OPC_TEXT || opcode == OPC_BINARY) begin
          if (fin) begin
            frame_route_next = ROUTE_SINGLE;
            msg_utf8_next    = '0;
          end else begin
            frame_route_next   = ROUTE_FRAG;
            first_pending_next = 1'b1;
            frag_nonempty_next = 1'b1;
            frag_is_text_next  = (opcode == OPC_TEXT);
            frag_utf8_next     = '0;
          end
        end else if (!fin) begin
          frame_route_next = ROUTE_DROP;
          drop_event_next  = EV_FRAG_CTRL;
        end else if (frame_len > LEN_W'(CONTROL_MAX_LEN)) begin
          frame_route_next = ROUTE_DROP;
          drop_event_next  = EV_LONG_CTRL;
        end else if (opcode == OPC_PING) begin
          frame_route_next = ROUTE_PING;
        end else if (opcode == OPC_PONG) begin
          frame_route_next = ROUTE_PONG;
        end else if (opcode == OPC_CLOSE) begin
          frame_route_next = ROUTE_CLOSE;
          close_index_next = CLOSE_IDX_HI;
          close_value_next = CODE_NORMAL;
          msg_utf8_next    = '0;
        end else begin
          frame_route_next = ROUTE_DROP;
          drop_event_next  = EV_UNKNOWN;
        end
        if (frame_len == '0) begin
          emit   = 1'b1;
          is_end = 1'b1;
        end
      end else if (bytes_left != '0) begin
        bytes_left_next = bytes_left - LEN_W'(1);
        emit      = 1'b1;
        with_byte = 1'b1;
        is_end    = (bytes_left_next == '0);
        unique case (frame_route)
          ROUTE_SINGLE: begin
            if (frame_opcode == OPC_TEXT) begin
              msg_utf8_next = utf8_feed(in_byte, msg_utf8);
            end
          end
          ROUTE_FRAG: begin
            if (frag_is_text) begin
              frag_utf8_next = utf8_feed(in_byte, frag_utf8);
            end
          end
          ROUTE_CLOSE: begin
            if (close_index == CLOSE_IDX_HI) begin
              close_value_next = {in_byte, 8'h00};
              close_index_next = CLOSE_IDX_LO;
            end else if (close_index == CLOSE_IDX_LO) begin
              close_value_next = close_value | {8'h00, in_byte};
              close_index_next = CLOSE_IDX_REASON;
            end else begin
              msg_utf8_next = utf8_feed(in_byte, msg_utf8);
            end
          end
          default: begin
          end
        endcase
      end
    end

    // The verdict looks at the state as this item leaves it.
    if (emit && is_end) begin
      unique case (frame_route_next)
        ROUTE_SINGLE: begin
          if (frame_opcode_next == OPC_TEXT) begin
            ev = (msg_utf8_next.bad || msg_utf8_next.left != 2'd0) ? EV_BAD_UTF8 : EV_TEXT;
          end else begin
            ev = EV_BINARY;
          end
        end
        ROUTE_FRAG: begin
          if (frame_opcode_next != OPC_CONT || !frame_fin_next) begin
            ev = EV_FRAG_STORED;
          end else begin
            frag_nonempty_next = 1'b0;
            if (frag_is_text_next) begin
              ev = (frag_utf8_next.bad || frag_utf8_next.left != 2'd0) ?
                   EV_BAD_UTF8 : EV_TEXT;
            end else begin
              ev = EV_BINARY;
            end
          end
        end
        ROUTE_PING: ev = EV_PING;
        ROUTE_PONG: ev = EV_PONG;
        ROUTE_CLOSE: begin
          ev = EV_CLOSE;
          if (close_index_next != CLOSE_IDX_REASON) begin
            code = CODE_NORMAL;
          end else if (msg_utf8_next.bad || msg_utf8_next.left != 2'd0) begin
            code = CODE_PROTOCOL;
          end else begin
            code = close_value_next;
          end
        end
        default: ev = drop_event_next;
      endcase
    end

    res_valid = emit;
    res.has_byte       = with_byte;
    res.out_byte       = with_byte ? in_byte : 8'h00;
    res.byte_kind      = frame_route_next;
    res.starts_message = first_pending_next;
    res.frame_end      = is_end;
    res.event_res      = ev;
    res.close_code     = code;
    if (emit) begin
      first_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      frame_opcode  <= OPC_CONT;
      frame_fin     <= 1'b0;
      frame_route   <= ROUTE_SINGLE;
      first_pending <= 1'b0;
      frag_is_text  <= 1'b0;
      frag_nonempty <= 1'b0;
      frag_utf8     <= '0;
      msg_utf8      <= '0;
      close_index   <= CLOSE_IDX_HI;
      close_value   <= CODE_NORMAL;
      drop_event    <= EV_FRAG_STORED;
    end else begin
      bytes_left    <= bytes_left_next;
      frame_opcode  <= frame_opcode_next;
      frame_fin     <= frame_fin_next;
      frame_route   <= frame_route_next;
      first_pending <= first_pending_next;
      frag_is_text  <= frag_is_text_next;
      frag_nonempty <= frag_nonempty_next;
      frag_utf8     <= frag_utf8_next;
      msg_utf8      <= msg_utf8_next;
      close_index   <= close_index_next;
      close_value   <= close_value_next;
      drop_event    <= drop_event_next;
    end
  end

endmodule

@@ rtl/core/wsmr_outq.sv @@
// Output register with a skid stage for the result channel.
// Depends on wsmr_pkg for the result type.
module wsmr_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsmr_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output wsmr_pkg::result_t head
);
  import wsmr_pkg::*;

  logic    main_valid, skid_valid;
  result_t main_data, skid_data;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign room      = !skid_valid;
  assign out_valid = main_valid;
  assign head      = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

@@ rtl/core/wsmr_checker.sv @@
// Port-level checker of the message reassembler, bound to the top level.
// Depends on wsmr_pkg and the assertion macro header.
`include "websocket_message_reassembler_core_assert.svh"

module wsmr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        has_byte,
  input logic [7:0]  out_byte,
  input logic [2:0]  byte_kind,
  input logic        frame_end,
  input logic [3:0]  event_res,
  input logic [15:0] close_code
);
  import wsmr_pkg::*;

  `WSMR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_byte) && $stable(event_res) && $stable(close_code),
                    "result changed while stalled")
  `WSMR_ASSERT_NOW(a_no_verdict_mid, clk, rst, out_valid && !frame_end,
                   event_res == EV_FRAG_STORED && close_code == 16'd0,
                   "verdict before frame end")
  `WSMR_ASSERT_NOW(a_empty_is_end, clk, rst, out_valid && !has_byte,
                   frame_end && out_byte == 8'h00, "byteless result not a frame end")
  `WSMR_ASSERT_NOW(a_close_route, clk, rst, out_valid && event_res == EV_CLOSE,
                   byte_kind == ROUTE_CLOSE, "close verdict off close route")

endmodule

bind websocket_message_reassembler_core wsmr_checker u_wsmr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .has_byte   (has_byte),
  .out_byte   (out_byte),
  .byte_kind  (byte_kind),
  .frame_end  (frame_end),
  .event_res  (event_res),
  .close_code (close_code)
);

@@ dv/wsmr_scoreboard_pkg.sv @@
// Scoreboard for the WebSocket message reassembler testbench: it predicts results per request.
// Depends on wsmr_pkg for the opcode, route, verdict and result types.
package wsmr_scoreboard_pkg;
  import wsmr_pkg::*;

  class reassembly_scoreboard;
    result_t                due_results[$];
    int unsigned            errors;

    // Frame in progress.
    logic [LEN_W-1:0]       frame_bytes_left;
    logic [3:0]             cur_opcode;
    logic                   cur_fin;
    route_t                 cur_route;
    logic                   first_open;
    event_t                 drop_verdict;
    // Fragmented message held by the consumer.
    logic                   frag_held;
    logic                   frag_text;
    logic [1:0]             frag_cont;
    logic                   frag_bad;
    // Single-frame text and close reason share one UTF-8 tracker.
    logic [1:0]             msg_cont;
    logic                   msg_bad;
    logic [1:0]             close_pos;
    logic [15:0]            close_status;

    function new();
      errors           = 0;
      frame_bytes_left = '0;
      cur_opcode       = OPC_CONT;
      cur_fin          = 1'b0;
      cur_route        = ROUTE_SINGLE;
      first_open       = 1'b0;
      drop_verdict     = EV_FRAG_STORED;
      frag_held        = 1'b0;
      frag_text        = 1'b0;
      frag_cont        = 2'd0;
      frag_bad         = 1'b0;
      msg_cont         = 2'd0;
      msg_bad          = 1'b0;
      close_pos        = CLOSE_IDX_HI;
      close_status     = CODE_NORMAL;
    endfunction

    // Lenient UTF-8: only lead and continuation bit patterns are checked.
    function void utf8_step(input logic [7:0] b, inout logic [1:0] cont, inout logic bad);
      if (cont != 2'd0) begin
        if (b[7:6] != 2'b10) bad = 1'b1;
        else cont = cont - 2'd1;
      end else if (!b[7]) begin
        cont = 2'd0;
      end else if (b[7:5] == 3'b110) begin
        cont = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cont = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cont = 2'd3;
      end else begin
        bad = 1'b1;
      end
    endfunction

    function void close_frame(output event_t ev, output logic [15:0] code);
      code = '0;
      case (cur_route)
        ROUTE_SINGLE: begin
          if (cur_opcode == OPC_TEXT) ev = (msg_bad || msg_cont != 2'd0) ? EV_BAD_UTF8 : EV_TEXT;
          else ev = EV_BINARY;
        end
        ROUTE_FRAG: begin
          if (cur_opcode != OPC_CONT || !cur_fin) begin
            ev = EV_FRAG_STORED;
          end else begin
            // The last fragment releases the held message, good or bad.
            frag_held = 1'b0;
            if (frag_text) ev = (frag_bad || frag_cont != 2'd0) ? EV_BAD_UTF8 : EV_TEXT;
            else ev = EV_BINARY;
          end
        end
        ROUTE_PING: ev = EV_PING;
        ROUTE_PONG: ev = EV_PONG;
        ROUTE_CLOSE: begin
          ev = EV_CLOSE;
          if (close_pos != CLOSE_IDX_REASON) code = CODE_NORMAL;
          else if (msg_bad || msg_cont != 2'd0) code = CODE_PROTOCOL;
          else code = close_status;
        end
        default: ev = drop_verdict;
      endcase
    endfunction

    function void queue_result(logic has, logic [7:0] b, logic last);
      result_t r;
      event_t  ev;
      logic [15:0] code;
      ev   = EV_FRAG_STORED;
      code = '0;
      if (last) close_frame(ev, code);
      r.has_byte       = has;
      r.out_byte       = b;
      r.byte_kind      = cur_route;
      r.starts_message = first_open;
      r.frame_end      = last;
      r.event_res      = ev;
      r.close_code     = code;
      first_open       = 1'b0;
      due_results.insert(due_results.size(), r);
    endfunction

    function void take_request(logic is_byte, logic [3:0] opc, logic f,
                               logic [LEN_W-1:0] len, logic [7:0] b);
      if (is_byte == OP_HEADER) begin
        cur_opcode       = opc;
        cur_fin          = f;
        frame_bytes_left = len;
        first_open       = 1'b0;
        drop_verdict     = EV_FRAG_STORED;
        if (opc == OPC_CONT) begin
          if (!frag_held) begin
            cur_route    = ROUTE_DROP;
            drop_verdict = EV_ORPHAN;
          end else begin
            cur_route = ROUTE_FRAG;
          end
        end else if (opc == OPC_TEXT || opc == OPC_BINARY) begin
          if (f) begin
            cur_route = ROUTE_SINGLE;
            msg_cont  = 2'd0;
            msg_bad   = 1'b0;
          end else begin
            cur_route  = ROUTE_FRAG;
            first_open = 1'b1;
            frag_held  = 1'b1;
            frag_text  = (opc == OPC_TEXT);
            frag_cont  = 2'd0;
            frag_bad   = 1'b0;
          end
        end else if (!f) begin
          cur_route    = ROUTE_DROP;
          drop_verdict = EV_FRAG_CTRL;
        end else if (len > LEN_W'(CONTROL_MAX_LEN_DEF)) begin
          cur_route    = ROUTE_DROP;
          drop_verdict = EV_LONG_CTRL;
        end else if (opc == OPC_PING) begin
          cur_route = ROUTE_PING;
        end else if (opc == OPC_PONG) begin
          cur_route = ROUTE_PONG;
        end else if (opc == OPC_CLOSE) begin
          cur_route    = ROUTE_CLOSE;
          close_pos    = CLOSE_IDX_HI;
          close_status = CODE_NORMAL;
          msg_cont     = 2'd0;
          msg_bad      = 1'b0;
        end else begin
          cur_route    = ROUTE_DROP;
          drop_verdict = EV_UNKNOWN;
        end
        if (len == '0) queue_result(1'b0, 8'h00, 1'b1);
        return;
      end

      if (frame_bytes_left == '0) return;
      frame_bytes_left = frame_bytes_left - 1'b1;
      case (cur_route)
        ROUTE_SINGLE: if (cur_opcode == OPC_TEXT) utf8_step(b, msg_cont, msg_bad);
        ROUTE_FRAG:   if (frag_text) utf8_step(b, frag_cont, frag_bad);
        ROUTE_CLOSE: begin
          if (close_pos == CLOSE_IDX_HI) begin
            close_status = {b, 8'h00};
            close_pos    = CLOSE_IDX_LO;
          end else if (close_pos == CLOSE_IDX_LO) begin
            close_status = close_status | {8'h00, b};
            close_pos    = CLOSE_IDX_REASON;
          end else begin
            utf8_step(b, msg_cont, msg_bad);
          end
        end
        default: ;
      endcase
      queue_result(1'b1, b, frame_bytes_left == '0);
    endfunction

    function void match_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual byte %02h kind %0d event %0d",
                 $time, got.out_byte, got.byte_kind, got.event_res);
        return;
      end
      want = due_results.pop_front();
      match_field("has_byte", want.has_byte, got.has_byte);
      match_field("out_byte", want.out_byte, got.out_byte);
      match_field("byte_kind", want.byte_kind, got.byte_kind);
      match_field("starts_message", want.starts_message, got.starts_message);
      match_field("frame_end", want.frame_end, got.frame_end);
      match_field("event_res", want.event_res, got.event_res);
      match_field("close_code", want.close_code, got.close_code);
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench of websocket_message_reassembler_core: directed and random frame traffic.
// Depends on wsmr_pkg and on the scoreboard in wsmr_scoreboard_pkg.
module tb_top;
  import wsmr_pkg::*;
  import wsmr_scoreboard_pkg::*;

  // An opcode with no meaning in the protocol; the block must treat it as unknown control.
  localparam logic [3:0] OPC_RESERVED_F = 4'hF;
  localparam int unsigned REQUEST_TARGET = 700;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             op = OP_HEADER;
  logic [3:0]       opcode = OPC_CONT;
  logic             fin = 1'b0;
  logic [LEN_W-1:0] frame_len = '0;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             has_byte;
  logic [7:0]       out_byte;
  logic [2:0]       byte_kind;
  logic             starts_message;
  logic             frame_end;
  logic [3:0]       event_res;
  logic [15:0]      close_code;

  reassembly_scoreboard rx_sb;

  // Payload of the frame about to be sent, and of the whole message when it is
  // cut into fragments.
  logic [7:0]  frame_bytes[$];
  logic [7:0]  msg_bytes[$];
  // Requests counted: headers and bytes inside a frame; stray bytes outside a frame do not count.
  int unsigned counted_requests = 0;
  // While set, neither side inserts gaps.
  logic        no_idle = 1'b0;

  websocket_message_reassembler_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .opcode         (opcode),
    .fin            (fin),
    .frame_len      (frame_len),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .has_byte       (has_byte),
    .out_byte       (out_byte),
    .byte_kind      (byte_kind),
    .starts_message (starts_message),
    .frame_end      (frame_end),
    .event_res      (event_res),
    .close_code     (close_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths shared by both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEN_W-1:0] wide_len();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[LEN_W-1:0];
  endfunction

  // Appends whole UTF-8 characters of one to four bytes with random content bits.
  function automatic void add_text(int chars);
    int k;
    for (int c = 0; c < chars; c++) begin
      k = $urandom_range(1, 4);
      case (k)
        1: frame_bytes.insert(frame_bytes.size(), {1'b0, 7'($urandom)});
        2: frame_bytes.insert(frame_bytes.size(), {3'b110, 5'($urandom)});
        3: frame_bytes.insert(frame_bytes.size(), {4'b1110, 4'($urandom)});
        default: frame_bytes.insert(frame_bytes.size(), {5'b11110, 3'($urandom)});
      endcase
      for (int j = 1; j < k; j++)
        frame_bytes.insert(frame_bytes.size(), {2'b10, 6'($urandom)});
    end
  endfunction

  function automatic void add_noise(int n);
    for (int j = 0; j < n; j++) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
  endfunction

  function automatic void spoil_one();
    if (frame_bytes.size() > 0)
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
  endfunction

  // One request: an optional gap, then valid held with a steady payload until
  // the block takes it. Valid stays high when the next request follows at once,
  // so it is never lowered and raised in the same step.
  task automatic push_request(input logic is_byte, input logic [3:0] opc, input logic f,
                              input logic [LEN_W-1:0] len, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= is_byte;
    opcode      <= opc;
    fin         <= f;
    frame_len   <= len;
    in_byte     <= b;
    do @(posedge clk); while (!in_ready);
    if (!(is_byte == OP_BYTE && rx_sb.frame_bytes_left == '0)) counted_requests++;
    rx_sb.take_request(is_byte, opc, f, len, b);
  endtask

  // The byte field is ignored on a header and the header fields on a byte, so
  // both carry random values there.
  task automatic send_header(input logic [3:0] opc, input logic f, input logic [LEN_W-1:0] len);
    push_request(OP_HEADER, opc, f, len, 8'($urandom));
  endtask

  task automatic send_data_byte(input logic [7:0] b);
    push_request(OP_BYTE, 4'($urandom), 1'($urandom), wide_len(), b);
  endtask

  // Header announcing all of frame_bytes, followed by only the first keep bytes.
  task automatic send_frame(input logic [3:0] opc, input logic f, input int keep);
    int n;
    n = frame_bytes.size();
    send_header(opc, f, LEN_W'(n));
    for (int i = 0; i < keep; i++) send_data_byte(frame_bytes[i]);
  endtask

  // A well-formed ping, pong or close, occasionally at the longest allowed length.
  task automatic send_control();
    logic [3:0] opc;
    int n;
    case ($urandom_range(0, 2))
      0: opc = OPC_PING;
      1: opc = OPC_PONG;
      default: opc = OPC_CLOSE;
    endcase
    frame_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      add_noise(CONTROL_MAX_LEN_DEF);
    end else if (opc == OPC_CLOSE) begin
      n = $urandom_range(0, 5);
      if (n == 1) begin
        add_noise(1);
      end else if (n > 1) begin
        add_noise(2);
        add_text(n - 2);
        if ($urandom_range(0, 3) == 0) spoil_one();
      end
    end else begin
      add_noise($urandom_range(0, 6));
    end
    send_frame(opc, 1'b1, frame_bytes.size());
  endtask

  // The sender holds off until every pending result has been taken, then stays
  // idle to let anything still inside the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (rx_sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: ready runs broken by stalls of random length.
  initial begin
    int run;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Every result the block hands over is checked against the oldest prediction.
  always @(posedge clk) begin
    result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.has_byte       = has_byte;
      seen.out_byte       = out_byte;
      seen.byte_kind      = byte_kind;
      seen.starts_message = starts_message;
      seen.frame_end      = frame_end;
      seen.event_res      = event_res;
      seen.close_code     = close_code;
      rx_sb.check_result(seen);
    end
  end

  initial begin
    logic [3:0] opc;
    int pick;
    int nfrag;
    int pos;
    int len;
    int k;
    rx_sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // A byte with no frame open must vanish without a result.
    send_data_byte(8'hFF);
    // A continuation with no message held is an orphan.
    frame_bytes = '{8'h00};
    send_frame(OPC_CONT, 1'b1, 1);
    // Single text frame whose four-byte lead is followed by ASCII: bad UTF-8.
    frame_bytes = '{8'hF0, 8'h41};
    send_frame(OPC_TEXT, 1'b1, 2);
    // An empty first fragment still opens a message.
    frame_bytes.delete();
    send_frame(OPC_TEXT, 1'b0, 0);
    // Control frames in the middle: a fragmented ping, then a close that is too
    // long and is abandoned by an unknown opcode header.
    send_header(OPC_PING, 1'b0, '0);
    frame_bytes = '{8'hE2};
    send_frame(OPC_CONT, 1'b0, 1);
    send_header(OPC_CLOSE, 1'b1, LEN_W'(CONTROL_MAX_LEN_DEF + 1));
    send_header(OPC_RESERVED_F, 1'b1, '0);
    // The three-byte character split across fragments completes here.
    frame_bytes = '{8'h82, 8'hAC};
    send_frame(OPC_CONT, 1'b1, 2);
    frame_bytes = '{8'h80};
    send_frame(OPC_PONG, 1'b1, 1);
    // Close with a broken reason gives the protocol error code, an empty one
    // the normal code.
    frame_bytes = '{8'h03, 8'hE8, 8'hFF};
    send_frame(OPC_CLOSE, 1'b1, 3);
    send_header(OPC_CLOSE, 1'b1, '0);
    // Largest length, left unfinished, then an empty binary message in two parts.
    send_header(OPC_BINARY, 1'b1, '1);
    send_header(OPC_BINARY, 1'b0, '0);
    send_header(OPC_CONT, 1'b1, '0);
    drain_results();

    // Random part: mostly well-formed messages with random content, the rest
    // broken frames, random headers and stray bytes.
    while (counted_requests < REQUEST_TARGET) begin
      no_idle = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        drain_results();
      end else if (pick < 27) begin
        opc = $urandom_range(0, 1) ? OPC_TEXT : OPC_BINARY;
        frame_bytes.delete();
        if (opc == OPC_TEXT) add_text($urandom_range(0, 4));
        else add_noise($urandom_range(0, 8));
        if ($urandom_range(0, 9) == 0) spoil_one();
        send_frame(opc, 1'b1, frame_bytes.size());
      end else if (pick < 52) begin
        // Fragmented message, the text check running across fragment borders,
        // sometimes with a control frame between fragments.
        opc = $urandom_range(0, 1) ? OPC_TEXT : OPC_BINARY;
        frame_bytes.delete();
        if (opc == OPC_TEXT) add_text($urandom_range(0, 6));
        else add_noise($urandom_range(0, 12));
        if ($urandom_range(0, 9) == 0) spoil_one();
        msg_bytes = frame_bytes;
        nfrag = $urandom_range(2, 4);
        pos = 0;
        for (int f = 0; f < nfrag; f++) begin
          if (f == nfrag - 1) len = msg_bytes.size() - pos;
          else len = $urandom_range(0, msg_bytes.size() - pos);
          frame_bytes.delete();
          for (int i = 0; i < len; i++)
            frame_bytes.insert(frame_bytes.size(), msg_bytes[pos + i]);
          send_frame((f == 0) ? opc : OPC_CONT, f == nfrag - 1, len);
          pos += len;
          if (f < nfrag - 1 && $urandom_range(0, 4) == 0) send_control();
        end
      end else if (pick < 70) begin
        send_control();
      end else if (pick < 80) begin
        // Truncated frame; the next header abandons it.
        frame_bytes.delete();
        add_noise($urandom_range(1, 6));
        send_frame(4'($urandom), 1'($urandom), $urandom_range(0, frame_bytes.size() - 1));
      end else if (pick < 92) begin
        // Any opcode, any fin, lengths that are short, around the control limit or anywhere.
        k = $urandom_range(0, 99);
        send_header(4'($urandom), 1'($urandom),
                    (k < 45) ? LEN_W'($urandom_range(0, 3)) :
                    (k < 75) ? LEN_W'($urandom_range(CONTROL_MAX_LEN_DEF - 2,
                                                     CONTROL_MAX_LEN_DEF + 3)) :
                    wide_len());
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) send_data_byte(8'($urandom));
      end else begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) send_data_byte(8'($urandom));
      end
    end

    no_idle = 1'b0;
    drain_results();
    if (rx_sb.errors == 0 && rx_sb.due_results.size() == 0) begin
      $display("websocket_message_reassembler_core verification clean");
    end else begin
      $display("websocket_message_reassembler_core verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #6000000;
    $display("websocket_message_reassembler_core verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/wsmr_pkg.sv
rtl/core/wsmr_engine.sv
rtl/core/wsmr_outq.sv
rtl/core/websocket_message_reassembler_core.sv
rtl/core/wsmr_checker.sv
dv/wsmr_scoreboard_pkg.sv
dv/tb_top.sv
